### sv/tra_pkg.sv
package tra_pkg;

  // Fixed field widths
  localparam int BYTE_W = 8;
  localparam int VAL_W  = 19;

  // Store geometry
  localparam int RING_DEPTH  = 5;
  localparam int NUM_ANCHORS = 3;
  localparam int OUT_FIELDS  = 3;

  localparam int SLOT_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int ANC_W  = (NUM_ANCHORS > 1) ? $clog2(NUM_ANCHORS) : 1;
  localparam int CNT_W  = $clog2(RING_DEPTH + 1);
  localparam int SUM_W  = VAL_W + CNT_W;
  localparam int STEP_W = $clog2(SUM_W);

  // Characters
  localparam logic [BYTE_W-1:0] CHAR_NUL  = 8'h00;
  localparam logic [BYTE_W-1:0] CHAR_ZERO = 8'h30;
  localparam logic [BYTE_W-1:0] CHAR_A    = 8'h61;
  localparam logic [BYTE_W-1:0] CHAR_N    = 8'h6E;

  // Digit weights, thousandths
  localparam logic signed [VAL_W-1:0] W_THOU = 19'sd1000;
  localparam logic signed [VAL_W-1:0] W_HUND = 19'sd100;
  localparam logic signed [VAL_W-1:0] W_TEN  = 19'sd10;

  // Per-anchor tag parser position
  typedef enum logic [3:0] {
    POS_IDLE = 4'd0,
    POS_A    = 4'd1,
    POS_N    = 4'd2,
    POS_SEP  = 4'd3,
    POS_D0   = 4'd4,
    POS_DOT  = 4'd5,
    POS_D2   = 4'd6,
    POS_D3   = 4'd7,
    POS_D4   = 4'd8,
    POS_DONE = 4'd9,
    POS_DEAD = 4'd15
  } pos_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_LOAD,
    ST_DIV,
    ST_STORE,
    ST_OUT
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic feed;       // byte word accepted
    logic chunk_fin;  // accepted word closes a chunk
    logic sum_step;
    logic div_load;
    logic div_step;
    logic div_store;
    logic out_load;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic sum_last;
    logic div_last;
    logic anchor_last;
    logic out_busy;
  } sts_t;

endpackage

### sv/tagged_range_parse_average_unit.sv
// Tagged range parser with ring averaging.
// Input channel (in_valid/in_ready): one text byte per word, in_data_byte,
// with in_chunk_end marking the last byte of a chunk. Each anchor tag "anK"
// found first in a chunk is followed by a separator and a "d.ddd" value.
// Result channel (out_valid/out_ready): one word per chunk, the truncated
// mean of the nonzero ring entries of each anchor, in thousandths.
// Timing: a byte that does not end a chunk only steps the parsers. A chunk-end
// byte starts the averaging pass: per anchor RING_DEPTH ring summing steps,
// a divider load, SUM_W restoring-division steps and a store, then the
// result register is loaded. The divider is bit-serial; in_ready is low
// during the pass.
// Reset (rst_n low, synchronous) clears the rings, slot pointer, parser
// state and the result valid flag at once; no clearing pass is needed.
// A stalled receiver holds the result word; bytes are still taken, and the
// next chunk-end pass waits before loading its result until the word drains.
module tagged_range_parse_average_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [tra_pkg::BYTE_W-1:0]        in_data_byte,
  input  logic                              in_chunk_end,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [tra_pkg::VAL_W-1:0]  out_mean_anchor0,
  output logic signed [tra_pkg::VAL_W-1:0]  out_mean_anchor1,
  output logic signed [tra_pkg::VAL_W-1:0]  out_mean_anchor2
);

  tra_pkg::cmd_t cmd;
  tra_pkg::sts_t sts;

  tra_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_chunk_end (in_chunk_end),
    .in_ready     (in_ready),
    .sts          (sts),
    .cmd          (cmd)
  );

  tra_datapath u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_data_byte     (in_data_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_mean_anchor0 (out_mean_anchor0),
    .out_mean_anchor1 (out_mean_anchor1),
    .out_mean_anchor2 (out_mean_anchor2)
  );

endmodule

### sv/tra_ctrl.sv
module tra_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            in_chunk_end,
  output logic            in_ready,
  input  tra_pkg::sts_t   sts,
  output tra_pkg::cmd_t   cmd
);

  tra_pkg::state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tra_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tra_pkg::ST_IDLE: begin
        if (in_valid && in_chunk_end) state_nxt = tra_pkg::ST_SUM;
      end
      tra_pkg::ST_SUM: begin
        if (sts.sum_last) state_nxt = tra_pkg::ST_LOAD;
      end
      tra_pkg::ST_LOAD: state_nxt = tra_pkg::ST_DIV;
      tra_pkg::ST_DIV: begin
        if (sts.div_last) state_nxt = tra_pkg::ST_STORE;
      end
      tra_pkg::ST_STORE: begin
        state_nxt = sts.anchor_last ? tra_pkg::ST_OUT : tra_pkg::ST_SUM;
      end
      tra_pkg::ST_OUT: begin
        if (!sts.out_busy) state_nxt = tra_pkg::ST_IDLE;
      end
      default: state_nxt = tra_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      tra_pkg::ST_IDLE: begin
        in_ready      = 1'b1;
        cmd.feed      = in_valid;
        cmd.chunk_fin = in_valid && in_chunk_end;
      end
      tra_pkg::ST_SUM:   cmd.sum_step  = 1'b1;
      tra_pkg::ST_LOAD:  cmd.div_load  = 1'b1;
      tra_pkg::ST_DIV:   cmd.div_step  = 1'b1;
      tra_pkg::ST_STORE: cmd.div_store = 1'b1;
      tra_pkg::ST_OUT:   cmd.out_load  = !sts.out_busy;
      default: begin
        cmd      = '0;
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

### sv/tra_datapath.sv
module tra_datapath (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  tra_pkg::cmd_t                           cmd,
  output tra_pkg::sts_t                           sts,
  input  logic [tra_pkg::BYTE_W-1:0]              in_data_byte,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic signed [tra_pkg::VAL_W-1:0]        out_mean_anchor0,
  output logic signed [tra_pkg::VAL_W-1:0]        out_mean_anchor1,
  output logic signed [tra_pkg::VAL_W-1:0]        out_mean_anchor2
);

  localparam int NA = tra_pkg::NUM_ANCHORS;
  localparam int RD = tra_pkg::RING_DEPTH;
  localparam int VW = tra_pkg::VAL_W;
  localparam int SW = tra_pkg::SUM_W;
  localparam int CW = tra_pkg::CNT_W;

  // Parser state per anchor
  tra_pkg::pos_t               pos_r   [NA];
  tra_pkg::pos_t               pos_nxt [NA];
  logic [NA-1:0]               done_r;
  logic [NA-1:0]               done_nxt;
  logic signed [VW-1:0]        acc_r   [NA];
  logic signed [VW-1:0]        acc_nxt [NA];

  // Rings and slot pointer
  logic signed [VW-1:0]        ring_r  [NA][RD];
  logic [tra_pkg::SLOT_W-1:0]  slot_r;

  // Averaging datapath
  logic [tra_pkg::ANC_W-1:0]   anchor_r;
  logic [tra_pkg::SLOT_W-1:0]  idx_r;
  logic signed [SW-1:0]        sum_r;
  logic [CW-1:0]               cnt_r;
  logic [CW-1:0]               div_r;
  logic [CW-1:0]               rem_r;
  logic [SW-1:0]               quo_r;
  logic                        neg_r;
  logic [tra_pkg::STEP_W-1:0]  step_r;
  logic signed [VW-1:0]        mean_r  [NA];
  logic signed [VW-1:0]        out_r   [tra_pkg::OUT_FIELDS];
  logic                        out_valid_r;

  logic signed [VW-1:0]        digit;
  logic signed [VW-1:0]        entry;
  logic [CW:0]                 trial;
  logic [CW:0]                 diff;
  logic                        ge;
  logic [SW-1:0]               signed_q;
  logic signed [VW-1:0]        mean_val;

  // Character as signed digit, no range check
  assign digit = signed'(VW'(in_data_byte)) - signed'(VW'(tra_pkg::CHAR_ZERO));

  // Tag and value parser, one per anchor
  for (genvar k = 0; k < NA; k++) begin : g_parse
    localparam logic [tra_pkg::BYTE_W-1:0] TagChar =
      tra_pkg::BYTE_W'(int'(tra_pkg::CHAR_ZERO) + k);
    logic tag_restart;
    assign tag_restart = (in_data_byte == tra_pkg::CHAR_A);

    always_comb begin
      pos_nxt[k]  = pos_r[k];
      done_nxt[k] = done_r[k];
      acc_nxt[k]  = acc_r[k];
      if (!done_r[k] && (pos_r[k] != tra_pkg::POS_DEAD)) begin
        if (in_data_byte == tra_pkg::CHAR_NUL) begin
          pos_nxt[k] = tra_pkg::POS_DEAD;
        end else begin
          case (pos_r[k])
            tra_pkg::POS_IDLE:
              pos_nxt[k] = tag_restart ? tra_pkg::POS_A : tra_pkg::POS_IDLE;
            tra_pkg::POS_A:
              pos_nxt[k] = (in_data_byte == tra_pkg::CHAR_N) ? tra_pkg::POS_N :
                           tag_restart ? tra_pkg::POS_A : tra_pkg::POS_IDLE;
            tra_pkg::POS_N:
              pos_nxt[k] = (in_data_byte == TagChar) ? tra_pkg::POS_SEP :
                           tag_restart ? tra_pkg::POS_A : tra_pkg::POS_IDLE;
            tra_pkg::POS_SEP: pos_nxt[k] = tra_pkg::POS_D0;
            tra_pkg::POS_D0: begin
              acc_nxt[k] = digit * tra_pkg::W_THOU;
              pos_nxt[k] = tra_pkg::POS_DOT;
            end
            tra_pkg::POS_DOT: pos_nxt[k] = tra_pkg::POS_D2;
            tra_pkg::POS_D2: begin
              acc_nxt[k] = acc_r[k] + digit * tra_pkg::W_HUND;
              pos_nxt[k] = tra_pkg::POS_D3;
            end
            tra_pkg::POS_D3: begin
              acc_nxt[k] = acc_r[k] + digit * tra_pkg::W_TEN;
              pos_nxt[k] = tra_pkg::POS_D4;
            end
            tra_pkg::POS_D4: begin
              acc_nxt[k]  = acc_r[k] + digit;
              done_nxt[k] = 1'b1;
              pos_nxt[k]  = tra_pkg::POS_DONE;
            end
            default: pos_nxt[k] = tra_pkg::POS_DEAD;
          endcase
        end
      end
    end
  end

  // Parser registers and ring write at chunk end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r <= '0;
      done_r <= '0;
      for (int k = 0; k < NA; k++) begin
        pos_r[k] <= tra_pkg::POS_IDLE;
        acc_r[k] <= '0;
        for (int i = 0; i < RD; i++) begin
          ring_r[k][i] <= '0;
        end
      end
    end else if (cmd.feed) begin
      if (cmd.chunk_fin) begin
        done_r <= '0;
        for (int k = 0; k < NA; k++) begin
          pos_r[k]           <= tra_pkg::POS_IDLE;
          acc_r[k]           <= '0;
          ring_r[k][slot_r]  <= done_nxt[k] ? acc_nxt[k] : '0;
        end
        slot_r <= (slot_r == tra_pkg::SLOT_W'(RD - 1)) ? '0 : slot_r + 1'b1;
      end else begin
        done_r <= done_nxt;
        for (int k = 0; k < NA; k++) begin
          pos_r[k] <= pos_nxt[k];
          acc_r[k] <= acc_nxt[k];
        end
      end
    end
  end

  // One restoring division step
  assign entry    = ring_r[anchor_r][idx_r];
  assign trial    = {rem_r, quo_r[SW-1]};
  assign diff     = trial - {1'b0, div_r};
  assign ge       = (trial >= {1'b0, div_r});
  assign signed_q = neg_r ? (~quo_r + 1'b1) : quo_r;
  assign mean_val = (div_r == '0) ? '0 : signed'(signed_q[VW-1:0]);

  // Ring sum, divider and mean store
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      anchor_r <= '0;
      idx_r    <= '0;
      sum_r    <= '0;
      cnt_r    <= '0;
      step_r   <= '0;
    end else if (cmd.chunk_fin) begin
      anchor_r <= '0;
      idx_r    <= '0;
      sum_r    <= '0;
      cnt_r    <= '0;
    end else if (cmd.sum_step) begin
      idx_r <= idx_r + 1'b1;
      if (entry != '0) begin
        sum_r <= sum_r + SW'(entry);
        cnt_r <= cnt_r + 1'b1;
      end
    end else if (cmd.div_load) begin
      step_r <= '0;
    end else if (cmd.div_step) begin
      step_r <= step_r + 1'b1;
    end else if (cmd.div_store) begin
      anchor_r <= (anchor_r == tra_pkg::ANC_W'(NA - 1)) ? '0 : anchor_r + 1'b1;
      idx_r    <= '0;
      sum_r    <= '0;
      cnt_r    <= '0;
    end
  end

  // Divider payload
  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      neg_r <= sum_r[SW-1];
      quo_r <= sum_r[SW-1] ? unsigned'(-sum_r) : unsigned'(sum_r);
      rem_r <= '0;
      div_r <= cnt_r;
    end else if (cmd.div_step) begin
      rem_r <= ge ? diff[CW-1:0] : trial[CW-1:0];
      quo_r <= {quo_r[SW-2:0], ge};
    end
    if (cmd.div_store) begin
      mean_r[anchor_r] <= mean_val;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  for (genvar f = 0; f < tra_pkg::OUT_FIELDS; f++) begin : g_out
    if (f < NA) begin : g_used
      always_ff @(posedge clk) begin
        if (cmd.out_load) out_r[f] <= mean_r[f];
      end
    end else begin : g_unused
      assign out_r[f] = '0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_mean_anchor0 = out_r[0];
  assign out_mean_anchor1 = out_r[1];
  assign out_mean_anchor2 = out_r[2];

  // Status to controller
  assign sts.sum_last    = (idx_r == tra_pkg::SLOT_W'(RD - 1));
  assign sts.div_last    = (step_r == tra_pkg::STEP_W'(SW - 1));
  assign sts.anchor_last = (anchor_r == tra_pkg::ANC_W'(NA - 1));
  assign sts.out_busy    = out_valid_r && !out_ready;

  // A pending result word is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_ready))
    else $error("result loaded over a pending word");

  // Chunk end clears all match flags
  a_match_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.chunk_fin |=> (done_r == '0))
    else $error("match flags not cleared at chunk end");

  // Zero count only with zero sum
  a_zero_count: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.div_load && (cnt_r == '0)) |-> (sum_r == '0))
    else $error("nonzero sum with no entries");

  // Slot pointer stays inside the ring
  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    slot_r <= tra_pkg::SLOT_W'(RD - 1))
    else $error("ring slot out of range");

endmodule

### tb/sv/tagged_range_parse_average_unit_tb.sv
module tagged_range_parse_average_unit_tb;
  import tra_pkg::*;

  localparam int ITEM_TARGET   = 1850;
  localparam int CYCLE_LIMIT   = 2000000;
  localparam int SETTLE_CYCLES = 200;
  localparam int HOLD_CYCLES   = 400;

  // one result word: mean per anchor, index 0 is anchor 0
  typedef logic [OUT_FIELDS-1:0][VAL_W-1:0] mean_set_t;

  logic                      clk;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic [BYTE_W-1:0]         in_data_byte = '0;
  logic                      in_chunk_end = 1'b0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic signed [VAL_W-1:0]   out_mean_anchor0;
  logic signed [VAL_W-1:0]   out_mean_anchor1;
  logic signed [VAL_W-1:0]   out_mean_anchor2;

  tagged_range_parse_average_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .in_chunk_end     (in_chunk_end),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_mean_anchor0 (out_mean_anchor0),
    .out_mean_anchor1 (out_mean_anchor1),
    .out_mean_anchor2 (out_mean_anchor2)
  );

  // Predictor state: rings, slot pointer, per-anchor tag search
  int        dist_ring [NUM_ANCHORS][RING_DEPTH];
  int        ring_slot;
  pos_t      tag_pos   [NUM_ANCHORS];
  bit        got_value [NUM_ANCHORS];
  int        value_acc [NUM_ANCHORS];
  mean_set_t expected_means[$];

  // Stimulus and traffic control
  logic [BYTE_W-1:0] chunk_buf[$];
  int          bytes_sent;
  int          err_count;
  bit          gaps_on;
  bit          stall_on;
  int          burst_left;
  int          hold_left;
  int          run_left;
  bit          rx_open;
  int unsigned cycle_count;
  mean_set_t   seen_word;
  mean_set_t   due_word;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------- predictor ----------------

  function automatic void clear_tag_search();
    for (int k = 0; k < NUM_ANCHORS; k++) begin
      tag_pos[k]   = POS_IDLE;
      got_value[k] = 1'b0;
      value_acc[k] = 0;
    end
  endfunction

  // a failed partial match starts over only on 'a'
  function automatic pos_t restart_pos(logic [BYTE_W-1:0] c);
    if (c == CHAR_A) return POS_A;
    return POS_IDLE;
  endfunction

  function automatic void step_anchor(int k, logic [BYTE_W-1:0] c);
    int digit;
    digit = int'(c) - int'(CHAR_ZERO);
    if (got_value[k] || tag_pos[k] == POS_DEAD) return;
    // NUL ends the searchable text; a half-read value is lost
    if (c == CHAR_NUL) begin
      tag_pos[k] = POS_DEAD;
      return;
    end
    case (tag_pos[k])
      POS_IDLE: tag_pos[k] = restart_pos(c);
      POS_A: begin
        if (c == CHAR_N) tag_pos[k] = POS_N;
        else tag_pos[k] = restart_pos(c);
      end
      POS_N: begin
        if (int'(c) == int'(CHAR_ZERO) + k) tag_pos[k] = POS_SEP;
        else tag_pos[k] = restart_pos(c);
      end
      POS_SEP: tag_pos[k] = POS_D0;
      POS_D0: begin
        value_acc[k] = digit * int'(W_THOU);
        tag_pos[k] = POS_DOT;
      end
      POS_DOT: tag_pos[k] = POS_D2;
      POS_D2: begin
        value_acc[k] += digit * int'(W_HUND);
        tag_pos[k] = POS_D3;
      end
      POS_D3: begin
        value_acc[k] += digit * int'(W_TEN);
        tag_pos[k] = POS_D4;
      end
      POS_D4: begin
        value_acc[k] += digit;
        got_value[k] = 1'b1;
        tag_pos[k] = POS_DONE;
      end
      default: tag_pos[k] = POS_DEAD;
    endcase
  endfunction

  // Track one accepted byte; a chunk end files the values and queues the means
  function automatic void track_ranging_byte(logic [BYTE_W-1:0] c, logic ends_chunk);
    int        total;
    int        hits;
    mean_set_t word;
    for (int k = 0; k < NUM_ANCHORS; k++) step_anchor(k, c);
    if (!ends_chunk) return;
    if (ring_slot >= RING_DEPTH) ring_slot = 0;
    for (int k = 0; k < NUM_ANCHORS; k++)
      dist_ring[k][ring_slot] = got_value[k] ? value_acc[k] : 0;
    ring_slot++;
    if (ring_slot >= RING_DEPTH) ring_slot = 0;
    word = '0;
    // zero entries count as absent; mean truncates toward zero
    for (int k = 0; k < NUM_ANCHORS; k++) begin
      total = 0;
      hits  = 0;
      for (int i = 0; i < RING_DEPTH; i++) begin
        if (dist_ring[k][i] != 0) begin
          total += dist_ring[k][i];
          hits++;
        end
      end
      if (hits != 0) word[k] = VAL_W'(total / hits);
    end
    expected_means.push_back(word);
    clear_tag_search();
  endfunction

  // ---------------- checking ----------------

  task automatic report_mismatch(string what, int field, logic [VAL_W-1:0] got,
                                 logic [VAL_W-1:0] want);
    err_count++;
    $display("mismatch: %s, anchor %0d: got %0d, expected %0d", what, field,
             $signed(got), $signed(want));
  endtask

  // compare each result word with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      seen_word = {out_mean_anchor2, out_mean_anchor1, out_mean_anchor0};
      if (expected_means.size() == 0) begin
        report_mismatch("result word with nothing expected", 0, seen_word[0], '0);
      end else begin
        due_word = expected_means.pop_front();
        for (int k = 0; k < OUT_FIELDS; k++)
          if (seen_word[k] !== due_word[k])
            report_mismatch("mean value", k, seen_word[k], due_word[k]);
      end
    end
  end

  // ---------------- traffic ----------------

  // receiver: long hold-off first, then its own stall pattern or always ready
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else if (!stall_on) begin
      out_ready <= 1'b1;
    end else begin
      if (run_left == 0) begin
        rx_open  = !rx_open;
        run_left = rx_open ? $urandom_range(1, 10) : $urandom_range(1, 6);
      end
      run_left--;
      out_ready <= rx_open;
    end
  end

  // timeout
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tagged_range_parse_average_unit regression: fail");
    $finish;
  end

  // offer one word and wait for its acceptance; gaps come between bursts
  task automatic send_byte(logic [BYTE_W-1:0] b, logic ends_chunk);
    int gap;
    if (gaps_on && burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = $urandom_range(1, 8);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    if (burst_left > 0) burst_left--;
    in_valid     <= 1'b1;
    in_data_byte <= b;
    in_chunk_end <= ends_chunk;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    track_ranging_byte(b, ends_chunk);
    bytes_sent++;
  endtask

  task automatic send_chunk();
    int n;
    n = chunk_buf.size();
    for (int i = 0; i < n; i++) send_byte(chunk_buf[i], i == n - 1);
  endtask

  // sender pauses until every expected word has come back
  task automatic drain_means();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_means.size() != 0) @(posedge clk);
  endtask

  // ---------------- chunk building ----------------

  function automatic void push_tag(int k, logic [BYTE_W-1:0] sep, logic [BYTE_W-1:0] d0,
                                   logic [BYTE_W-1:0] dot, logic [BYTE_W-1:0] d2,
                                   logic [BYTE_W-1:0] d3, logic [BYTE_W-1:0] d4);
    chunk_buf.push_back(CHAR_A);
    chunk_buf.push_back(CHAR_N);
    chunk_buf.push_back(BYTE_W'(int'(CHAR_ZERO) + k));
    chunk_buf.push_back(sep);
    chunk_buf.push_back(d0);
    chunk_buf.push_back(dot);
    chunk_buf.push_back(d2);
    chunk_buf.push_back(d3);
    chunk_buf.push_back(d4);
  endfunction

  // mostly decimal digits, now and then any non-NUL byte
  function automatic logic [BYTE_W-1:0] value_char();
    case ($urandom_range(0, 7))
      0:       return BYTE_W'($urandom_range(1, 255));
      1:       return CHAR_ZERO;
      default: return BYTE_W'(int'(CHAR_ZERO) + $urandom_range(0, 9));
    endcase
  endfunction

  // Random chunk: mostly well-formed tags with random values, mixed with noise,
  // broken tags, repeated tags, an odd NUL and an odd early cut
  function automatic void build_random_chunk();
    int                segs;
    int                len;
    logic [BYTE_W-1:0] sep;
    logic [BYTE_W-1:0] dot;
    chunk_buf.delete();
    segs = $urandom_range(1, 5);
    repeat (segs) begin
      case ($urandom_range(0, 9))
        0: begin
          repeat ($urandom_range(1, 6)) begin
            case ($urandom_range(0, 3))
              0: chunk_buf.push_back(BYTE_W'($urandom_range(0, 255)));
              1: chunk_buf.push_back(CHAR_A);
              2: chunk_buf.push_back(CHAR_N);
              default: chunk_buf.push_back(BYTE_W'(int'(CHAR_ZERO) + $urandom_range(0, 2)));
            endcase
          end
        end
        1: begin
          chunk_buf.push_back(CHAR_A);
          case ($urandom_range(0, 3))
            0: ;
            1: chunk_buf.push_back(CHAR_N);
            2: begin
              chunk_buf.push_back(CHAR_A);
              chunk_buf.push_back(CHAR_N);
            end
            default: begin
              chunk_buf.push_back(CHAR_N);
              chunk_buf.push_back(BYTE_W'(int'(CHAR_ZERO) + $urandom_range(3, 9)));
            end
          endcase
        end
        default: begin
          sep = ($urandom_range(0, 3) == 0) ? BYTE_W'($urandom_range(0, 255)) : 8'h20;
          dot = ($urandom_range(0, 4) == 0) ? BYTE_W'($urandom_range(0, 255)) : 8'h2E;
          if ($urandom_range(0, 9) == 0)
            push_tag($urandom_range(0, 2), sep, CHAR_ZERO, dot, CHAR_ZERO, CHAR_ZERO,
                     CHAR_ZERO);
          else
            push_tag($urandom_range(0, 2), sep, value_char(), dot, value_char(),
                     value_char(), value_char());
        end
      endcase
    end
    if ($urandom_range(0, 9) == 0)
      chunk_buf[$urandom_range(0, chunk_buf.size() - 1)] = CHAR_NUL;
    if ($urandom_range(0, 7) == 0) begin
      len = $urandom_range(1, chunk_buf.size());
      while (chunk_buf.size() > len) void'(chunk_buf.pop_back());
    end
  endfunction

  // ---------------- tests ----------------

  // extremes, overlapping tag, NUL after a complete value, cut-off value
  task automatic test_directed();
    gaps_on  = 1'b0;
    stall_on = 1'b0;
    chunk_buf.delete();
    chunk_buf.push_back(CHAR_A);
    push_tag(1, 8'h20, 8'hFF, 8'h2E, 8'hFF, 8'hFF, 8'hFF);
    send_chunk();
    chunk_buf.delete();
    push_tag(0, 8'h20, 8'h01, 8'h2E, 8'h01, 8'h01, 8'h01);
    chunk_buf.push_back(CHAR_NUL);
    send_chunk();
    chunk_buf.delete();
    push_tag(2, 8'h20, 8'h31, 8'h2E, 8'h32, 8'h33, 8'h34);
    void'(chunk_buf.pop_back());
    void'(chunk_buf.pop_back());
    send_chunk();
    drain_means();
  endtask

  // back-to-back words, receiver always ready
  task automatic test_steady_stream();
    gaps_on  = 1'b0;
    stall_on = 1'b0;
    while (bytes_sent < 500) begin
      build_random_chunk();
      send_chunk();
    end
    drain_means();
  endtask

  // sender bursts and receiver stalls together
  task automatic test_bursty_traffic();
    gaps_on  = 1'b1;
    stall_on = 1'b1;
    while (bytes_sent < 1400) begin
      build_random_chunk();
      send_chunk();
    end
    drain_means();
  endtask

  // receiver holds off while the sender keeps offering words
  task automatic test_output_backpressure();
    gaps_on  = 1'b0;
    stall_on = 1'b0;
    do begin
      hold_left = HOLD_CYCLES;
      repeat (5) begin
        build_random_chunk();
        send_chunk();
      end
      drain_means();
    end while (bytes_sent < ITEM_TARGET);
  endtask

  initial begin
    err_count  = 0;
    bytes_sent = 0;
    burst_left = 0;
    hold_left  = 0;
    run_left   = 0;
    rx_open    = 1'b0;
    ring_slot  = 0;
    clear_tag_search();
    rst_n <= 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_steady_stream();
    test_bursty_traffic();
    test_output_backpressure();
    drain_means();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (err_count == 0 && expected_means.size() == 0)
      $display("tagged_range_parse_average_unit regression: pass");
    else
      $display("tagged_range_parse_average_unit regression: fail");
    $finish;
  end

endmodule
